### rtl/core/rvs_pkg.sv
// Package for the RRIP-style victim selector: sizes, priority codes,
// row type, controller/datapath command and status structs, row helpers.
// No dependencies.
`default_nettype none

package rvs_pkg;

    localparam int SETS   = 64;
    localparam int WAYS   = 16;
    localparam int SET_W  = 6;
    localparam int WAY_W  = 4;
    localparam int RND_W  = 16;
    localparam int VICT_W = 4;
    localparam int PRIO_W = 3;

    localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int STEP_W = $clog2(RND_W + 1);
    localparam int ROW_W  = WAYS * PRIO_W;
    localparam int NPRIO  = 1 << PRIO_W;

    localparam logic [PRIO_W-1:0] PRIO_HIT  = PRIO_W'(7);
    localparam logic [PRIO_W-1:0] PRIO_FILL = PRIO_W'(1);

    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef logic [WAYS-1:0][PRIO_W-1:0] row_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic cap_row;
        logic upd_wr;
        logic find_min;
        logic age;
        logic prep;
        logic mod_step;
        logic scan_step;
        logic out_load;
    } rvs_cmd_t;

    typedef struct packed {
        logic in_victim;
        logic in_set_ok;
        logic is_victim;
        logic mod_last;
        logic scan_hit;
        logic out_busy;
    } rvs_sts_t;

    function automatic logic [WAYS-1:0] zero_mask(input row_t row);
        logic [WAYS-1:0] m;
        m = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            m[w] = (row[w] == '0);
        end
        return m;
    endfunction

    function automatic logic [PRIO_W-1:0] row_min(input row_t row);
        logic [NPRIO-1:0]  seen;
        logic [PRIO_W-1:0] m;
        seen = '0;
        m    = '1;
        for (int w = 0; w < WAYS; w++)
        begin
            seen[row[w]] = 1'b1;
        end
        for (int v = NPRIO - 1; v >= 0; v--)
        begin
            if (seen[v])
            begin
                m = PRIO_W'(v);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rrip_style_victim_selector.sv
// RRIP-style victim selector, top level: ties controller and datapath.
// Depends on rvs_pkg, rvs_ctrl, rvs_dp (which holds rvs_ram).
//
// Usage: one input channel (in_valid/in_ready) carries a transaction that is
// either a victim request (req_type 0) or a hit/fill update (req_type 1).
// The output channel (out_valid/out_ready) returns one transaction per
// victim request: victim_way and aged. Updates return nothing.
// Items are handled one at a time; in_ready is high only while idle.
// An update reads its set from the RAM, captures the row and writes it back
// with the update applied; the block then returns to idle for the next one.
// A victim request passes set RAM read, row capture, minimum search, aging,
// zero-way count, the bit-serial modulo of random_value by the number of
// zero ways and the scan, which walks one way per cycle, on to the output
// register. A victim request to a set out of range goes straight to the
// output register with way 0, aged 0.
// Reset clears all priorities at once through per-set valid bits; the
// block accepts a transaction in the first cycle after reset.
// A result waits in the output register while the receiver stalls; the
// next transaction is still accepted and runs until it needs that register.
`default_nettype none

module rrip_style_victim_selector
    import rvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              req_type,
    input  wire logic [SET_W-1:0]  set_index,
    input  wire logic [WAY_W-1:0]  way_index,
    input  wire logic              hit,
    input  wire logic              is_writeback,
    input  wire logic [RND_W-1:0]  random_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [VICT_W-1:0]      victim_way,
    output logic                   aged
);

    rvs_cmd_t cmd;
    rvs_sts_t sts;

    rvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rvs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .set_index    (set_index),
        .way_index    (way_index),
        .hit          (hit),
        .is_writeback (is_writeback),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .victim_way   (victim_way),
        .aged         (aged)
    );

endmodule

`default_nettype wire

### rtl/core/rvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/rvs_ctrl.sv
// Controller state machine of the victim selector.
// Depends on rvs_pkg (command and status structs).
`default_nettype none

module rvs_ctrl
    import rvs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire rvs_sts_t sts,
    output rvs_cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_READ = 10'b00_0000_0010,
        S_ROW  = 10'b00_0000_0100,
        S_UPD  = 10'b00_0000_1000,
        S_MIN  = 10'b00_0001_0000,
        S_AGE  = 10'b00_0010_0000,
        S_CNT  = 10'b00_0100_0000,
        S_MOD  = 10'b00_1000_0000,
        S_SCAN = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_set_ok)
                    begin
                        state_next = S_READ;
                    end
                    else if (sts.in_victim)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                cmd.cap_row = 1'b1;
                state_next  = sts.is_victim ? S_MIN : S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_MIN:
            begin
                cmd.find_min = 1'b1;
                state_next   = S_AGE;
            end
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = S_CNT;
            end
            S_CNT:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/rvs_dp.sv
// Datapath of the victim selector: priority RAM, row valid bits, aging,
// modulo unit, zero-way scan and output register.
// Depends on rvs_pkg and rvs_ram.
`default_nettype none

module rvs_dp
    import rvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rvs_cmd_t          cmd,
    output rvs_sts_t               sts,
    input  wire logic              req_type,
    input  wire logic [SET_W-1:0]  set_index,
    input  wire logic [WAY_W-1:0]  way_index,
    input  wire logic              hit,
    input  wire logic              is_writeback,
    input  wire logic [RND_W-1:0]  random_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [VICT_W-1:0]      victim_way,
    output logic                   aged
);

    logic [SETS-1:0]   row_vld_reg;
    logic              vld_q_reg;
    logic              out_valid_reg;

    logic              req_reg;
    logic [SET_AW-1:0] set_reg;
    logic [WAY_AW-1:0] lane_reg;
    logic              way_ok_reg;
    logic              hit_reg;
    logic              wb_reg;
    logic [RND_W-1:0]  rnd_reg;

    row_t              row_reg;
    logic [PRIO_W-1:0] min_reg;
    logic              aged_reg;
    logic [WAYS-1:0]   mask_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WAY_AW-1:0] ptr_reg;
    logic [VICT_W-1:0] victim_reg;
    logic [VICT_W-1:0] victim_out_reg;
    logic              aged_out_reg;

    logic [ROW_W-1:0]  rd_data;
    logic [ROW_W-1:0]  wr_data;
    logic              wr_en;
    row_t              upd_row;
    row_t              aged_row;
    logic [CNT_W:0]    mod_dvd;
    logic [CNT_W-1:0]  rem_next;
    logic              scan_hit;

    rvs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (set_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        upd_row = row_reg;
        if (way_ok_reg && !(hit_reg && wb_reg))
        begin
            upd_row[lane_reg] = hit_reg ? PRIO_HIT : PRIO_FILL;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            aged_row[w] = row_reg[w] - min_reg;
        end
    end

    assign wr_en   = cmd.upd_wr || (cmd.age && aged_reg);
    assign wr_data = cmd.upd_wr ? ROW_W'(upd_row) : ROW_W'(aged_row);

    assign mod_dvd  = {rem_reg, rnd_reg[RND_W-1]};
    assign rem_next = (mod_dvd >= {1'b0, count_reg}) ? CNT_W'(mod_dvd - {1'b0, count_reg})
                                                     : CNT_W'(mod_dvd);
    assign scan_hit = mask_reg[ptr_reg] && (rem_reg == '0);

    always_comb
    begin
        sts           = '0;
        sts.in_victim = (req_type == REQ_VICTIM);
        sts.in_set_ok = (32'(set_index) < SETS);
        sts.is_victim = (req_reg == REQ_VICTIM);
        sts.mod_last  = (step_reg == STEP_W'(RND_W - 1));
        sts.scan_hit  = scan_hit;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[set_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            set_reg    <= SET_AW'(set_index);
            lane_reg   <= WAY_AW'(way_index);
            way_ok_reg <= (32'(way_index) < WAYS);
            hit_reg    <= hit;
            wb_reg     <= is_writeback;
            rnd_reg    <= random_value;
            victim_reg <= '0;
            aged_reg   <= 1'b0;
        end
        if (cmd.rd_en)
        begin
            vld_q_reg <= row_vld_reg[set_reg];
        end
        if (cmd.cap_row)
        begin
            row_reg <= vld_q_reg ? row_t'(rd_data) : '0;
        end
        if (cmd.find_min)
        begin
            min_reg  <= row_min(row_reg);
            aged_reg <= (zero_mask(row_reg) == '0);
        end
        if (cmd.age && aged_reg)
        begin
            row_reg <= aged_row;
        end
        if (cmd.prep)
        begin
            mask_reg  <= zero_mask(row_reg);
            count_reg <= CNT_W'($countones(zero_mask(row_reg)));
            rem_reg   <= '0;
            step_reg  <= '0;
            ptr_reg   <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= rem_next;
            rnd_reg  <= {rnd_reg[RND_W-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.scan_step)
        begin
            if (scan_hit)
            begin
                victim_reg <= VICT_W'(ptr_reg);
            end
            else if (mask_reg[ptr_reg])
            begin
                rem_reg <= rem_reg - 1'b1;
            end
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            victim_out_reg <= scan_hit && cmd.scan_step ? VICT_W'(ptr_reg) : victim_reg;
            aged_out_reg   <= aged_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign victim_way = victim_out_reg;
    assign aged       = aged_out_reg;

endmodule

`default_nettype wire

### sim/rrip_style_victim_selector_tb.sv
// Self-checking testbench for rrip_style_victim_selector: directed and random
// victim requests and hit/fill updates, checked against a scoreboard model.
// Depends on rvs_pkg and the rrip_style_victim_selector RTL.
`timescale 1ns / 100ps

module rrip_style_victim_selector_tb;
    import rvs_pkg::*;

    localparam int          RANDOM_ITEMS = 1450;
    localparam int          CALM_AFTER   = 1250;
    localparam int          DRAIN_AT     = 700;
    localparam int          TAIL_CYCLES  = 60;
    localparam int unsigned WATCHDOG_NS  = 2_000_000;

    typedef struct {
        logic [VICT_W-1:0] victim_way;
        logic              aged;
    } victim_t;

    class victim_scoreboard;
        logic [PRIO_W-1:0] prio [SETS][WAYS];
        victim_t           expected_victims [$];
        int unsigned       errors;

        function new();
            errors = 0;
            for (int s = 0; s < SETS; s++)
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    prio[s][i] = '0;
                end
            end
        endfunction

        function int pending();
            return expected_victims.size();
        endfunction

        function void note_transaction(logic rt, logic [SET_W-1:0] s, logic [WAY_W-1:0] wy,
                                       logic h, logic wb, logic [RND_W-1:0] rnd);
            victim_t           res;
            int                zeros [WAYS];
            int                count;
            logic [PRIO_W-1:0] least;
            if (rt == REQ_VICTIM)
            begin
                res.victim_way = '0;
                res.aged       = 1'b0;
                if (int'(s) < SETS)
                begin
                    count = 0;
                    least = '1;
                    for (int i = 0; i < WAYS; i++)
                    begin
                        if (prio[s][i] == '0)
                        begin
                            zeros[count] = i;
                            count++;
                        end
                        if (prio[s][i] < least)
                        begin
                            least = prio[s][i];
                        end
                    end
                    if (count == 0)
                    begin
                        res.aged = 1'b1;
                        for (int i = 0; i < WAYS; i++)
                        begin
                            prio[s][i] = prio[s][i] - least;
                            if (prio[s][i] == '0)
                            begin
                                zeros[count] = i;
                                count++;
                            end
                        end
                    end
                    res.victim_way = VICT_W'(zeros[int'(rnd) % count]);
                end
                expected_victims = {expected_victims, res};
            end
            else if (int'(s) < SETS && int'(wy) < WAYS)
            begin
                if (!h)
                begin
                    prio[s][wy] = PRIO_FILL;
                end
                else if (!wb)
                begin
                    prio[s][wy] = PRIO_HIT;
                end
            end
        endfunction

        function void check_victim(logic [VICT_W-1:0] way, logic ag);
            victim_t exp_v;
            if (expected_victims.size() == 0)
            begin
                $error("unexpected victim transaction: victim_way %0d aged %0d", way, ag);
                errors++;
                return;
            end
            exp_v = expected_victims.pop_front();
            if (way !== exp_v.victim_way)
            begin
                $error("victim_way expected %0d actual %0d", exp_v.victim_way, way);
                errors++;
            end
            if (ag !== exp_v.aged)
            begin
                $error("aged expected %0d actual %0d", exp_v.aged, ag);
                errors++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              req_type     = 1'b0;
    logic [SET_W-1:0]  set_index    = '0;
    logic [WAY_W-1:0]  way_index    = '0;
    logic              hit          = 1'b0;
    logic              is_writeback = 1'b0;
    logic [RND_W-1:0]  random_value = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [VICT_W-1:0] victim_way;
    logic              aged;

    victim_scoreboard sb = new();
    bit               calm = 1'b0;
    int               items_sent = 0;
    int               hot_sets [4];

    rrip_style_victim_selector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .set_index    (set_index),
        .way_index    (way_index),
        .hit          (hit),
        .is_writeback (is_writeback),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .victim_way   (victim_way),
        .aged         (aged)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("rrip_style_victim_selector test failed");
        $finish;
    end

    task automatic send_item(logic rt, logic [SET_W-1:0] s, logic [WAY_W-1:0] wy,
                             logic h, logic wb, logic [RND_W-1:0] rnd);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rt;
        set_index    <= s;
        way_index    <= wy;
        hit          <= h;
        is_writeback <= wb;
        random_value <= rnd;
        do @(posedge clk); while (!in_ready);
        sb.note_transaction(rt, s, wy, h, wb, rnd);
        items_sent++;
    endtask

    task automatic send_victim(logic [SET_W-1:0] s, logic [RND_W-1:0] rnd);
        send_item(REQ_VICTIM, s, WAY_W'($urandom), 1'($urandom), 1'($urandom), rnd);
    endtask

    task automatic send_update(logic [SET_W-1:0] s, logic [WAY_W-1:0] wy, logic h, logic wb);
        send_item(REQ_UPDATE, s, wy, h, wb, RND_W'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [SET_W-1:0] pick_set();
        if ($urandom_range(0, 3) != 0)
        begin
            return SET_W'(hot_sets[$urandom_range(0, 3)]);
        end
        return SET_W'($urandom_range(0, SETS - 1));
    endfunction

    initial
    begin
        int  stall;
        bit  nxt;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_victim(victim_way, aged);
            end
            if (stall > 0)
            begin
                stall--;
                nxt = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 5) - 1;
                nxt   = 1'b0;
            end
            else
            begin
                nxt = 1'b1;
            end
            out_ready <= nxt;
        end
    end

    initial
    begin
        bit drained;
        int n;
        drained = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            hot_sets[i] = $urandom_range(0, SETS - 1);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_victim(SET_W'(0), 16'h0000);
        send_victim(SET_W'(SETS - 1), 16'hFFFF);
        for (int wy = 0; wy < WAYS; wy++)
        begin
            if (wy == 0)
                send_update(SET_W'(5), WAY_W'(wy), 1'b1, 1'b0);
            else if (wy == 3)
                send_update(SET_W'(5), WAY_W'(wy), 1'b1, 1'b1);
            else if (wy == WAYS - 1)
                send_update(SET_W'(5), WAY_W'(wy), 1'b0, 1'b1);
            else
                send_update(SET_W'(5), WAY_W'(wy), 1'b0, 1'b0);
        end
        send_victim(SET_W'(5), 16'hFFFF);
        send_update(SET_W'(5), WAY_W'(3), 1'b1, 1'b0);
        send_victim(SET_W'(5), 16'hABCD);
        send_victim(SET_W'(5), 16'h1234);

        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= CALM_AFTER)
            begin
                calm = 1'b1;
            end
            if (!drained && items_sent >= DRAIN_AT)
            begin
                drain();
                drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                logic [SET_W-1:0] s;
                s = pick_set();
                for (int wy = 0; wy < WAYS; wy++)
                begin
                    if ($urandom_range(0, 7) != 0)
                    begin
                        send_update(s, WAY_W'(wy), 1'($urandom),
                                    $urandom_range(0, 3) == 0);
                    end
                end
                n = $urandom_range(1, 3);
                repeat (n) send_victim(s, RND_W'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    send_item(1'($urandom), ($urandom_range(0, 1) == 0) ? pick_set()
                                                                      : SET_W'($urandom),
                              WAY_W'($urandom), 1'($urandom), 1'($urandom),
                              RND_W'($urandom));
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("rrip_style_victim_selector test passed");
        end
        else
        begin
            $display("rrip_style_victim_selector test failed");
        end
        $finish;
    end

endmodule
